FILE: sv/sst_pkg.sv
package sst_pkg;

   // Table geometry
   localparam int MAX_SLOTS = 8;
   localparam int SLOT_W    = $clog2(MAX_SLOTS);
   localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

   // Sequence wrap window
   localparam logic [31:0] WRAP_HIGH = 32'hFFFF_0000;
   localparam logic [31:0] WRAP_LOW  = 32'h0000_FFFF;

   // Opcodes
   localparam logic [2:0] OP_ACTIVATE   = 3'd0;
   localparam logic [2:0] OP_DEACTIVATE = 3'd1;
   localparam logic [2:0] OP_ADD        = 3'd2;
   localparam logic [2:0] OP_REMOVE     = 3'd3;
   localparam logic [2:0] OP_LOOKUP     = 3'd4;
   localparam logic [2:0] OP_UPDATE     = 3'd5;
   localparam logic [2:0] OP_SET_READY  = 3'd6;
   localparam logic [2:0] OP_QUERY      = 3'd7;

   // Status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_FULL      = 3'd1;
   localparam logic [2:0] ST_NOT_FOUND = 3'd2;
   localparam logic [2:0] ST_BAD_INDEX = 3'd3;
   localparam logic [2:0] ST_NOT_CONN  = 3'd4;
   localparam logic [2:0] ST_STALE     = 3'd5;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [31:0] conn_handle;
      logic [7:0]  slot_index;
      logic [31:0] sequence_req;
      logic [7:0]  claimed_player;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [2:0] slot_out;
      logic [3:0] player_count;
      logic       is_ready;
      logic       all_ready;
      logic       num_corrected;
   } rsp_type;

   // Command broadcast to every cell during a scan
   typedef struct packed {
      logic              nop;
      logic [2:0]        op;
      logic [31:0]       handle;
      logic [SLOT_W-1:0] idx;
      logic [31:0]       seq;
      logic [7:0]        pnum;
   } cmd_type;

   // Partial result handed from cell to cell
   typedef struct packed {
      logic              claimed;
      logic [SLOT_W-1:0] slot;
      logic [2:0]        status;
      logic              rdy;
      logic              corr;
      logic              any_occ;
      logic              all_ok;
   } carry_type;

   function automatic logic seq_accept(input logic [31:0] last, input logic [31:0] next);
      return (last == 32'd0) || (next > last) || ((last > WRAP_HIGH) && (next < WRAP_LOW));
   endfunction

endpackage

FILE: sv/sst_cell.sv
module sst_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [sst_pkg::SLOT_W-1:0]    cell_idx,
   input  sst_pkg::cmd_type              cmd,
   input  logic                          tok_in,
   input  sst_pkg::carry_type            carry_in,
   output logic                          tok_out,
   output sst_pkg::carry_type            carry_out
);

   logic [31:0]        handle_ff, handle_in;
   logic [31:0]        seq_ff, seq_in;
   logic               rdy_ff, rdy_in;
   logic               tok_ff;
   sst_pkg::carry_type carry_ff, carry_next_in;
   logic               hit;

   // Slot operation when the scan token passes through this cell
   always_comb begin
      handle_in     = handle_ff;
      seq_in        = seq_ff;
      rdy_in        = rdy_ff;
      carry_next_in = carry_in;
      hit           = (cmd.idx == cell_idx);
      if (tok_in && !cmd.nop) begin
         unique case (cmd.op) inside
            sst_pkg::OP_ACTIVATE: begin
               handle_in = (cell_idx == '0) ? cmd.handle : 32'd0;
               seq_in    = 32'd0;
               rdy_in    = 1'b0;
            end
            sst_pkg::OP_DEACTIVATE: begin
               handle_in = 32'd0;
               seq_in    = 32'd0;
               rdy_in    = 1'b0;
            end
            sst_pkg::OP_ADD: begin
               if (!carry_in.claimed && handle_ff == 32'd0) begin
                  handle_in             = cmd.handle;
                  carry_next_in.claimed = 1'b1;
                  carry_next_in.slot    = cell_idx;
                  carry_next_in.status  = sst_pkg::ST_OK;
               end
            end
            sst_pkg::OP_REMOVE, sst_pkg::OP_LOOKUP: begin
               if (!carry_in.claimed && handle_ff == cmd.handle) begin
                  if (cmd.op == sst_pkg::OP_REMOVE) begin
                     handle_in = 32'd0;
                  end
                  carry_next_in.claimed = 1'b1;
                  carry_next_in.slot    = cell_idx;
                  carry_next_in.status  = sst_pkg::ST_OK;
               end
            end
            sst_pkg::OP_UPDATE: begin
               if (hit) begin
                  if (handle_ff == 32'd0) begin
                     carry_next_in.status = sst_pkg::ST_NOT_CONN;
                  end else if (sst_pkg::seq_accept(seq_ff, cmd.seq)) begin
                     seq_in             = cmd.seq;
                     carry_next_in.corr = (cmd.pnum != 8'(cell_idx));
                  end else begin
                     carry_next_in.status = sst_pkg::ST_STALE;
                  end
               end
            end
            sst_pkg::OP_SET_READY: begin
               if (hit) begin
                  rdy_in = 1'b1;
               end
            end
            sst_pkg::OP_QUERY: begin
               if (hit) begin
                  carry_next_in.rdy = rdy_ff;
               end
            end
            default: begin
            end
         endcase
      end
      // all-ready accumulation over the post-operation slot state
      carry_next_in.any_occ = carry_in.any_occ | (handle_in != 32'd0);
      carry_next_in.all_ok  = carry_in.all_ok & ((handle_in == 32'd0) | rdy_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         handle_ff <= 32'd0;
         seq_ff    <= 32'd0;
         rdy_ff    <= 1'b0;
         tok_ff    <= 1'b0;
      end else begin
         handle_ff <= handle_in;
         seq_ff    <= seq_in;
         rdy_ff    <= rdy_in;
         tok_ff    <= tok_in;
      end
   end

   // Partial result moves on to the neighbor
   always_ff @(posedge clock) begin
      carry_ff <= carry_next_in;
   end

   assign tok_out   = tok_ff;
   assign carry_out = carry_ff;

endmodule

FILE: sv/session_slot_table_seq_filter.sv
// Connection slot table with sequence replay filter. One request is in work at a time:
// a scan token walks the row of MAX_SLOTS slot cells, one cell per cycle, and each cell
// applies the request to its own slot. The next request is taken only after the token has
// left the last cell and the block is no longer busy. The response side holds up to two
// results, so a new request is taken while a finished result still waits on rsp_ready.
// Every request yields exactly one response.
module session_slot_table_seq_filter (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sst_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sst_pkg::rsp_type  rsp_data
);

   localparam int N = sst_pkg::MAX_SLOTS;

   logic                        busy_ff, busy_in;
   logic [sst_pkg::CNT_W-1:0]   count_ff, count_in;
   sst_pkg::cmd_type            cmd_ff, cmd_in;
   sst_pkg::carry_type          carry0_ff, carry0_in;
   logic                        tok0_ff;
   logic                        rsp_vld_ff, hold_vld_ff;
   sst_pkg::rsp_type            rsp_ff, hold_ff, res;
   logic                        accept, done;

   logic [N:0]                  tok;
   sst_pkg::carry_type          carry [N+1];

   assign req_ready = !busy_ff && !hold_vld_ff;
   assign accept    = req_valid && req_ready;

   // Request decode and early rejects
   always_comb begin
      cmd_in.nop     = 1'b0;
      cmd_in.op      = req_data.opcode;
      cmd_in.handle  = req_data.conn_handle;
      cmd_in.idx     = req_data.slot_index[sst_pkg::SLOT_W-1:0];
      cmd_in.seq     = req_data.sequence_req;
      cmd_in.pnum    = req_data.claimed_player;
      carry0_in      = '0;
      carry0_in.all_ok = 1'b1;
      carry0_in.status = sst_pkg::ST_OK;
      unique case (req_data.opcode) inside
         sst_pkg::OP_ACTIVATE: begin
            if (req_data.conn_handle == 32'd0) begin
               cmd_in.nop       = 1'b1;
               carry0_in.status = sst_pkg::ST_NOT_CONN;
            end
         end
         sst_pkg::OP_DEACTIVATE: begin
         end
         sst_pkg::OP_ADD: begin
            carry0_in.status = sst_pkg::ST_FULL;
            if (req_data.conn_handle == 32'd0) begin
               cmd_in.nop       = 1'b1;
               carry0_in.status = sst_pkg::ST_NOT_CONN;
            end else if (count_ff >= sst_pkg::CNT_W'(N)) begin
               cmd_in.nop = 1'b1;
            end
         end
         sst_pkg::OP_REMOVE, sst_pkg::OP_LOOKUP: begin
            carry0_in.status = sst_pkg::ST_NOT_FOUND;
            if (req_data.conn_handle == 32'd0) begin
               cmd_in.nop = 1'b1;
            end
         end
         sst_pkg::OP_UPDATE, sst_pkg::OP_SET_READY, sst_pkg::OP_QUERY: begin
            if (req_data.slot_index >= 8'(N)) begin
               cmd_in.nop       = 1'b1;
               carry0_in.status = sst_pkg::ST_BAD_INDEX;
            end
         end
         default: begin
         end
      endcase
   end

   assign tok[0]   = tok0_ff;
   assign carry[0] = carry0_ff;

   // Row of slot cells
   for (genvar g = 0; g < N; g++) begin : g_cell
      sst_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_idx  (sst_pkg::SLOT_W'(g)),
         .cmd       (cmd_ff),
         .tok_in    (tok[g]),
         .carry_in  (carry[g]),
         .tok_out   (tok[g+1]),
         .carry_out (carry[g+1])
      );
   end

   assign done = tok[N];

   // Occupied count after the finished operation
   always_comb begin
      count_in = count_ff;
      if (done && !cmd_ff.nop) begin
         unique case (cmd_ff.op)
            sst_pkg::OP_ACTIVATE:   count_in = sst_pkg::CNT_W'(1);
            sst_pkg::OP_DEACTIVATE: count_in = '0;
            sst_pkg::OP_ADD: begin
               if (carry[N].claimed) count_in = count_ff + sst_pkg::CNT_W'(1);
            end
            sst_pkg::OP_REMOVE: begin
               if (carry[N].claimed) count_in = count_ff - sst_pkg::CNT_W'(1);
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      res.status        = carry[N].status;
      res.slot_out      = 3'(carry[N].slot);
      res.player_count  = 4'(count_in);
      res.is_ready      = carry[N].rdy;
      res.all_ready     = carry[N].any_occ & carry[N].all_ok;
      res.num_corrected = carry[N].corr;
   end

   assign busy_in = accept ? 1'b1 : (done ? 1'b0 : busy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         tok0_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         tok0_ff  <= accept;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= cmd_in;
         carry0_ff <= carry0_in;
      end
   end

   // Two-entry result buffer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         hold_vld_ff <= 1'b0;
      end else if (rsp_vld_ff && rsp_ready) begin
         if (hold_vld_ff) begin
            rsp_ff      <= hold_ff;
            hold_vld_ff <= 1'b0;
         end else if (done) begin
            rsp_ff <= res;
         end else begin
            rsp_vld_ff <= 1'b0;
         end
      end else if (!rsp_vld_ff) begin
         if (done) begin
            rsp_ff     <= res;
            rsp_vld_ff <= 1'b1;
         end
      end else if (done) begin
         hold_ff     <= res;
         hold_vld_ff <= 1'b1;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_one_token: assert property (@(posedge clock) disable iff (reset) $onehot0(tok))
      else $error("more than one scan token in the cell row");
   a_done_busy: assert property (@(posedge clock) disable iff (reset) done |-> busy_ff)
      else $error("scan finished with no request in work");
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= sst_pkg::CNT_W'(N))
      else $error("occupied count above table size");
   a_hold_order: assert property (@(posedge clock) disable iff (reset)
      hold_vld_ff |-> rsp_vld_ff)
      else $error("held result without an output result ahead of it");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff && tok0_ff)
      else $error("transfer did not start a scan");
`endif

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int IDLE_LIMIT  = 3000;
   localparam int RANDOM_REQS = 1020;
   localparam int CALM_TAIL   = 150;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   sst_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   sst_pkg::rsp_type rsp_data;

   // Shadow copy of the slot table
   logic [31:0]                   shadow_handle [sst_pkg::MAX_SLOTS];
   logic [31:0]                   shadow_seq [sst_pkg::MAX_SLOTS];
   logic [sst_pkg::MAX_SLOTS-1:0] shadow_ready;
   int unsigned                   shadow_count;
   bit                            shadow_room;

   sst_pkg::rsp_type owed_replies[$];
   int unsigned      mismatch_count = 0;
   int unsigned      quiet_cycles = 0;
   int unsigned      stall_left = 0;
   bit               idle_on = 1'b1;

   typedef struct {
      sst_pkg::req_type req;
      bit               typed;
      sst_pkg::rsp_type want;
   } plan_row_type;

   session_slot_table_seq_filter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic sst_pkg::req_type mk_req(logic [2:0] op, logic [31:0] hnd,
                                               logic [7:0] idx, logic [31:0] seq,
                                               logic [7:0] pnum);
      sst_pkg::req_type r;
      r.opcode         = op;
      r.conn_handle    = hnd;
      r.slot_index     = idx;
      r.sequence_req   = seq;
      r.claimed_player = pnum;
      return r;
   endfunction

   function automatic sst_pkg::rsp_type mk_rsp(logic [2:0] st, logic [2:0] slot,
                                               logic [3:0] cnt, logic rdy, logic all,
                                               logic corr);
      sst_pkg::rsp_type o;
      o.status        = st;
      o.slot_out      = slot;
      o.player_count  = cnt;
      o.is_ready      = rdy;
      o.all_ready     = all;
      o.num_corrected = corr;
      return o;
   endfunction

   function automatic void wipe_shadow();
      for (int k = 0; k < sst_pkg::MAX_SLOTS; k++) begin
         shadow_handle[k] = '0;
         shadow_seq[k]    = '0;
      end
      shadow_ready = '0;
      shadow_count = 0;
   endfunction

   function automatic int first_holder(logic [31:0] hnd);
      if (hnd == '0) return -1;
      for (int k = 0; k < sst_pkg::MAX_SLOTS; k++)
         if (shadow_handle[k] == hnd) return k;
      return -1;
   endfunction

   // Replay filter: fresh on empty history, on a larger value, or on a wrap
   function automatic bit seq_is_fresh(logic [31:0] prev, logic [31:0] nxt);
      if (prev == '0 || nxt > prev) return 1'b1;
      return (prev > sst_pkg::WRAP_HIGH) && (nxt < sst_pkg::WRAP_LOW);
   endfunction

   // Apply one request to the shadow table and return the reply it owes
   function automatic sst_pkg::rsp_type slot_table_apply(sst_pkg::req_type r);
      sst_pkg::rsp_type o;
      int               hit;
      bit               all;
      o = '0;
      o.status = sst_pkg::ST_OK;
      hit = -1;
      unique case (r.opcode)
         sst_pkg::OP_ACTIVATE: begin
            if (r.conn_handle == '0) begin
               o.status = sst_pkg::ST_NOT_CONN;
            end else begin
               wipe_shadow();
               shadow_handle[0] = r.conn_handle;
               shadow_count = 1;
               shadow_room = 1'b1;
            end
         end
         sst_pkg::OP_DEACTIVATE: begin
            wipe_shadow();
            shadow_room = 1'b0;
         end
         sst_pkg::OP_ADD: begin
            if (r.conn_handle == '0) begin
               o.status = sst_pkg::ST_NOT_CONN;
            end else begin
               o.status = sst_pkg::ST_FULL;
               if (shadow_count < sst_pkg::MAX_SLOTS) begin
                  for (int k = 0; k < sst_pkg::MAX_SLOTS && hit < 0; k++)
                     if (shadow_handle[k] == '0) hit = k;
                  if (hit >= 0) begin
                     shadow_handle[hit] = r.conn_handle;
                     shadow_count++;
                     o.slot_out = hit[2:0];
                     o.status = sst_pkg::ST_OK;
                  end
               end
            end
         end
         sst_pkg::OP_REMOVE: begin
            hit = first_holder(r.conn_handle);
            if (hit < 0) begin
               o.status = sst_pkg::ST_NOT_FOUND;
            end else begin
               shadow_handle[hit] = '0;
               if (shadow_count > 0) shadow_count--;
               o.slot_out = hit[2:0];
            end
         end
         sst_pkg::OP_LOOKUP: begin
            hit = first_holder(r.conn_handle);
            if (hit < 0) o.status = sst_pkg::ST_NOT_FOUND;
            else o.slot_out = hit[2:0];
         end
         sst_pkg::OP_UPDATE: begin
            if (r.slot_index >= sst_pkg::MAX_SLOTS) begin
               o.status = sst_pkg::ST_BAD_INDEX;
            end else if (shadow_handle[r.slot_index] == '0) begin
               o.status = sst_pkg::ST_NOT_CONN;
            end else if (!seq_is_fresh(shadow_seq[r.slot_index], r.sequence_req)) begin
               o.status = sst_pkg::ST_STALE;
            end else begin
               shadow_seq[r.slot_index] = r.sequence_req;
               o.num_corrected = (r.claimed_player != r.slot_index);
            end
         end
         sst_pkg::OP_SET_READY: begin
            if (r.slot_index >= sst_pkg::MAX_SLOTS) o.status = sst_pkg::ST_BAD_INDEX;
            else shadow_ready[r.slot_index] = 1'b1;
         end
         default: begin
            if (r.slot_index >= sst_pkg::MAX_SLOTS) o.status = sst_pkg::ST_BAD_INDEX;
            else o.is_ready = shadow_ready[r.slot_index];
         end
      endcase
      all = (shadow_count != 0);
      for (int k = 0; k < sst_pkg::MAX_SLOTS; k++)
         if (shadow_handle[k] != '0 && !shadow_ready[k]) all = 1'b0;
      o.player_count = shadow_count[3:0];
      o.all_ready = all;
      return o;
   endfunction

   task automatic report_mismatch(string msg);
      if (mismatch_count < 100) $display("ERROR at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // Drive one request, hold it until the transfer, then maybe leave a gap
   task automatic push_request(sst_pkg::req_type r, bit typed, sst_pkg::rsp_type want);
      sst_pkg::rsp_type predicted;
      req_data  <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = slot_table_apply(r);
      owed_replies.push_back(typed ? want : predicted);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   // Result side: check each transfer, stall ready in random bursts
   always @(posedge clock) begin : rsp_side
      sst_pkg::rsp_type want;
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (owed_replies.size() == 0) begin
               report_mismatch($sformatf("reply with nothing owed: %p", rsp_data));
            end else begin
               want = owed_replies.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch($sformatf("status %0d, want %0d",
                                            rsp_data.status, want.status));
               if (rsp_data.slot_out !== want.slot_out)
                  report_mismatch($sformatf("slot_out %0d, want %0d",
                                            rsp_data.slot_out, want.slot_out));
               if (rsp_data.player_count !== want.player_count)
                  report_mismatch($sformatf("player_count %0d, want %0d",
                                            rsp_data.player_count, want.player_count));
               if (rsp_data.is_ready !== want.is_ready)
                  report_mismatch($sformatf("is_ready %0b, want %0b",
                                            rsp_data.is_ready, want.is_ready));
               if (rsp_data.all_ready !== want.all_ready)
                  report_mismatch($sformatf("all_ready %0b, want %0b",
                                            rsp_data.all_ready, want.all_ready));
               if (rsp_data.num_corrected !== want.num_corrected)
                  report_mismatch($sformatf("num_corrected %0b, want %0b",
                                            rsp_data.num_corrected, want.num_corrected));
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ready  <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 11);
            rsp_ready  <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin
      plan_row_type plan[$];
      logic [31:0]  handle_pool [8];
      logic [31:0]  hnd;
      logic [31:0]  seq;
      logic [31:0]  prev;
      logic [7:0]   idx;
      logic [7:0]   pnum;
      logic [2:0]   op;
      int unsigned  pick;
      int unsigned  k;

      wipe_shadow();
      shadow_room = 1'b0;
      foreach (handle_pool[i]) begin
         handle_pool[i] = $urandom;
         if (handle_pool[i] == '0) handle_pool[i] = 32'd1;
      end

      // Directed: empty table, fill to full, error codes, filter edges, all-ready
      plan.push_back('{mk_req(sst_pkg::OP_QUERY, 0, 0, 0, 0), 1,
                       mk_rsp(sst_pkg::ST_OK, 0, 0, 0, 0, 0)});
      plan.push_back('{mk_req(sst_pkg::OP_ACTIVATE, 0, 0, 0, 0), 1,
                       mk_rsp(sst_pkg::ST_NOT_CONN, 0, 0, 0, 0, 0)});
      plan.push_back('{mk_req(sst_pkg::OP_ACTIVATE, 32'hFFFF_FFFF, 0, 0, 0), 1,
                       mk_rsp(sst_pkg::ST_OK, 0, 1, 0, 0, 0)});
      plan.push_back('{mk_req(sst_pkg::OP_ADD, 32'h0000_0001, 0, 0, 0), 0, '0});
      plan.push_back('{mk_req(sst_pkg::OP_ADD, 32'h8000_0000, 0, 0, 0), 0, '0});
      plan.push_back('{mk_req(sst_pkg::OP_ADD, 32'hA5A5_A5A5, 0, 0, 0), 0, '0});
      plan.push_back('{mk_req(sst_pkg::OP_ADD, 32'h5A5A_5A5A, 0, 0, 0), 0, '0});
      plan.push_back('{mk_req(sst_pkg::OP_ADD, 32'h0000_0002, 0, 0, 0), 0, '0});
      plan.push_back('{mk_req(sst_pkg::OP_ADD, 32'h0000_0003, 0, 0, 0), 0, '0});
      plan.push_back('{mk_req(sst_pkg::OP_ADD, 32'h0000_0004, 0, 0, 0), 0, '0});
      plan.push_back('{mk_req(sst_pkg::OP_ADD, 32'h1234_5678, 0, 0, 0), 1,
                       mk_rsp(sst_pkg::ST_FULL, 0, 8, 0, 0, 0)});
      plan.push_back('{mk_req(sst_pkg::OP_ADD, 0, 0, 0, 0), 1,
                       mk_rsp(sst_pkg::ST_NOT_CONN, 0, 8, 0, 0, 0)});
      plan.push_back('{mk_req(sst_pkg::OP_LOOKUP, 32'hA5A5_A5A5, 0, 0, 0), 0, '0});
      plan.push_back('{mk_req(sst_pkg::OP_LOOKUP, 0, 0, 0, 0), 1,
                       mk_rsp(sst_pkg::ST_NOT_FOUND, 0, 8, 0, 0, 0)});
      plan.push_back('{mk_req(sst_pkg::OP_REMOVE, 32'h0000_0001, 0, 0, 0), 0, '0});
      plan.push_back('{mk_req(sst_pkg::OP_UPDATE, 0, 8'hFF, 32'hFFFF_FFFF, 8'hFF), 1,
                       mk_rsp(sst_pkg::ST_BAD_INDEX, 0, 7, 0, 0, 0)});
      plan.push_back('{mk_req(sst_pkg::OP_UPDATE, 0, 1, 32'd10, 1), 0, '0});
      plan.push_back('{mk_req(sst_pkg::OP_UPDATE, 0, 2, 32'hFFFF_0001, 2), 0, '0});
      plan.push_back('{mk_req(sst_pkg::OP_UPDATE, 0, 2, 32'h0000_0000, 8'hFF), 0, '0});
      plan.push_back('{mk_req(sst_pkg::OP_UPDATE, 0, 2, 32'hFFFF_FFFF, 2), 0, '0});
      plan.push_back('{mk_req(sst_pkg::OP_UPDATE, 0, 2, 32'hFFFF_FFFF, 2), 0, '0});
      plan.push_back('{mk_req(sst_pkg::OP_SET_READY, 0, 1, 0, 0), 0, '0});
      plan.push_back('{mk_req(sst_pkg::OP_SET_READY, 0, 8, 0, 0), 1,
                       mk_rsp(sst_pkg::ST_BAD_INDEX, 0, 7, 0, 0, 0)});
      plan.push_back('{mk_req(sst_pkg::OP_QUERY, 0, 1, 0, 0), 0, '0});
      plan.push_back('{mk_req(sst_pkg::OP_QUERY, 0, 8'hFF, 0, 0), 1,
                       mk_rsp(sst_pkg::ST_BAD_INDEX, 0, 7, 0, 0, 0)});
      plan.push_back('{mk_req(sst_pkg::OP_DEACTIVATE, 0, 0, 0, 0), 1,
                       mk_rsp(sst_pkg::ST_OK, 0, 0, 0, 0, 0)});
      plan.push_back('{mk_req(sst_pkg::OP_ACTIVATE, 32'h0000_0007, 0, 0, 0), 0, '0});
      plan.push_back('{mk_req(sst_pkg::OP_SET_READY, 0, 0, 0, 0), 0, '0});

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) push_request(plan[i].req, plan[i].typed, plan[i].want);

      // Random: weighted opcodes, handles mostly from a small pool or the table
      for (int n = 0; n < RANDOM_REQS; n++) begin
         if (n % 100 == 0) idle_on = ($urandom_range(0, 3) != 0);
         if (n >= RANDOM_REQS - CALM_TAIL) idle_on = 1'b0;

         pick = $urandom_range(0, 99);
         if (pick < 3)       op = sst_pkg::OP_ACTIVATE;
         else if (pick < 5)  op = sst_pkg::OP_DEACTIVATE;
         else if (pick < 25) op = sst_pkg::OP_ADD;
         else if (pick < 37) op = sst_pkg::OP_REMOVE;
         else if (pick < 49) op = sst_pkg::OP_LOOKUP;
         else if (pick < 79) op = sst_pkg::OP_UPDATE;
         else if (pick < 91) op = sst_pkg::OP_SET_READY;
         else                op = sst_pkg::OP_QUERY;

         pick = $urandom_range(0, 19);
         if (pick == 0)      hnd = '0;
         else if (pick == 1) hnd = $urandom;
         else                hnd = handle_pool[$urandom_range(0, 7)];
         k = $urandom_range(0, sst_pkg::MAX_SLOTS - 1);
         if ((op == sst_pkg::OP_REMOVE || op == sst_pkg::OP_LOOKUP) &&
             $urandom_range(0, 9) < 7 && shadow_handle[k] != '0)
            hnd = shadow_handle[k];

         if ($urandom_range(0, 99) < 85) idx = $urandom_range(0, sst_pkg::MAX_SLOTS - 1);
         else                            idx = $urandom_range(0, 255);

         prev = (idx < sst_pkg::MAX_SLOTS) ? shadow_seq[idx] : 32'd0;
         case ($urandom_range(0, 9)) inside
            [0:4]:   seq = prev + $urandom_range(1, 1000);
            5:       seq = prev - $urandom_range(0, 3);
            6:       seq = $urandom;
            7:       seq = sst_pkg::WRAP_HIGH + $urandom_range(0, 'hFFFF);
            8:       seq = $urandom_range(0, 'h1FFFF);
            default: seq = prev;
         endcase

         if ($urandom_range(0, 9) < 8) pnum = idx;
         else                          pnum = $urandom_range(0, 255);

         push_request(mk_req(op, hnd, idx, seq, pnum), 1'b0, '0);

         // Let the block drain completely once mid-run
         if (n == RANDOM_REQS / 2) begin
            req_valid <= 1'b0;
            wait (owed_replies.size() == 0);
            @(posedge clock);
         end
      end
      req_valid <= 1'b0;

      wait (owed_replies.size() == 0);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
